// ===== design/dcyf_pkg.sv =====
`default_nettype none

package dcyf_pkg;

  // field widths
  localparam int MODE_W  = 3;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OUT_W   = 42;

  // internal widths
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam int Q100_W      = YEAR_W + RECIP_W - RECIP_SHIFT;
  localparam int DOY_W       = 9;
  localparam int DNUM_W      = 21;
  localparam int DIFF_W      = 22;
  localparam int YDIFF_W     = YEAR_W + 1;
  localparam int DEN_W       = 18;
  localparam int NUM_W       = 31;
  localparam int MAG_W       = NUM_W - 1;
  localparam int DIV_STEPS   = 6;
  localparam int FRONT_STAGES = 5;

  // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 12-bit y
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

  // convention selector codes
  localparam logic [MODE_W-1:0] MODE_ACT360   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ACT365F  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_30_360   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_30E_360  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_30E_ISDA = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ACT_ACT  = 3'd5;

  // year lengths and denominators
  localparam logic [DOY_W-1:0] DAYS_COMMON = 9'd365;
  localparam logic [DOY_W-1:0] DAYS_LEAP   = 9'd366;
  localparam logic [DEN_W-1:0] DEN_360     = 18'd360;
  localparam logic [DEN_W-1:0] DEN_365     = 18'd365;
  localparam logic [DEN_W-1:0] DEN_CC      = 18'd133225;
  localparam logic [DEN_W-1:0] DEN_CL      = 18'd133590;
  localparam logic [DEN_W-1:0] DEN_LL      = 18'd133956;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [DOY_W-1:0]   doy;
    logic [DNUM_W-1:0]  dnum;
    logic               leap;
    logic               feb_end;
    logic               valid;
  } date_info_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             err;
  } frac_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic             neg;
    logic             err;
  } div_ctl_t;

  // days before the first of a month in a common year
  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] month);
    logic [DOY_W-1:0] days;
    unique case (month)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = '0;
    endcase
    return days;
  endfunction

  // days in a month, zero for a month that does not exist
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:        len = 5'd31;
      default:                   len = '0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== design/day_count_year_fraction_unit.sv =====
// Day-count year fraction unit. Each beat carries a convention selector (ACT/360, ACT/365F,
// 30/360 US, 30E/360, 30E/360 ISDA, ACT/ACT ISDA), two calendar dates and a final-period flag,
// and returns the signed year fraction with FRAC_BITS fraction bits, rounded to nearest with
// ties away from zero, plus an error flag for an unused selector or an invalid date (the
// fraction is then zero). The unit is a flat pipeline that takes one beat per clock while
// the output is ready or a stage is empty. Five stages decode the dates and form the exact
// rational, a restoring divider resolves six quotient bits per stage, and one last stage
// rounds and restores the sign. Stalls on the output fill bubbles first, so the input stays
// ready until every stage holds a beat.
`default_nettype none

module day_count_year_fraction_unit import dcyf_pkg::*; #(
  parameter int MIN_YEAR  = 1900,
  parameter int MAX_YEAR  = 2199,
  parameter int FRAC_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [MODE_W-1:0]       mode_i,
  input  logic [YEAR_W-1:0]       start_year_i,
  input  logic [MONTH_W-1:0]      start_month_i,
  input  logic [DAY_W-1:0]        start_day_i,
  input  logic [YEAR_W-1:0]       end_year_i,
  input  logic [MONTH_W-1:0]      end_month_i,
  input  logic [DAY_W-1:0]        end_day_i,
  input  logic                    final_period_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] fraction_o,
  output logic                    error_o
);

  localparam int QUOT_BITS  = MAG_W + FRAC_BITS + 1;
  localparam int DIV_STAGES = (QUOT_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int WORK_W     = DIV_STAGES * DIV_STEPS;
  localparam int NV         = FRONT_STAGES + DIV_STAGES + 1;

  logic [NV-1:0]      valid_q;
  logic [NV-1:0]      valid_d;
  logic [NV-1:0]      load;
  logic [MODE_W-1:0]  mode_s0_q;
  logic [MODE_W-1:0]  mode_s1_q;
  logic               fin_s0_q;
  logic               fin_s1_q;
  date_info_t         start_info;
  date_info_t         end_info;
  frac_t              frac;
  logic [WORK_W-1:0]  work_s [DIV_STAGES+1];
  div_ctl_t           ctl_s  [DIV_STAGES+1];
  logic [WORK_W-1:0]  rounded;
  logic [OUT_W-1:0]   yf_mag;
  logic [OUT_W-1:0]   yf_d;
  logic [OUT_W-1:0]   yf_q;
  logic               err_q;

  // stage load enables: a stage moves when empty or when the next one moves
  always_comb begin
    load[NV-1] = !valid_q[NV-1] || out_ready_i;
    for (int k = NV - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
    for (int k = 0; k < NV; k++) begin
      if (load[k]) begin
        valid_d[k] = (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
      end else begin
        valid_d[k] = valid_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = valid_q[NV-1];

  // selector and flag follow the dates through the decode stages
  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      mode_s0_q <= mode_i;
      fin_s0_q  <= final_period_i;
    end
    if (load[1]) begin
      mode_s1_q <= mode_s0_q;
      fin_s1_q  <= fin_s0_q;
    end
  end

  // date decode
  dcyf_date_unit #(
    .MIN_YEAR (MIN_YEAR),
    .MAX_YEAR (MAX_YEAR)
  ) u_start_date (
    .clk_i     (clk_i),
    .load_s0_i (load[0]),
    .load_s1_i (load[1]),
    .year_i    (start_year_i),
    .month_i   (start_month_i),
    .day_i     (start_day_i),
    .info_o    (start_info)
  );

  dcyf_date_unit #(
    .MIN_YEAR (MIN_YEAR),
    .MAX_YEAR (MAX_YEAR)
  ) u_end_date (
    .clk_i     (clk_i),
    .load_s0_i (load[0]),
    .load_s1_i (load[1]),
    .year_i    (end_year_i),
    .month_i   (end_month_i),
    .day_i     (end_day_i),
    .info_o    (end_info)
  );

  // exact numerator and denominator per convention
  dcyf_frac_prep u_prep (
    .clk_i          (clk_i),
    .load_s2_i      (load[2]),
    .load_s3_i      (load[3]),
    .load_s4_i      (load[4]),
    .mode_i         (mode_s1_q),
    .final_period_i (fin_s1_q),
    .start_i        (start_info),
    .end_i          (end_info),
    .frac_o         (frac)
  );

  // divider input: magnitude scaled by one extra fraction bit for rounding
  always_comb begin
    work_s[0]    = WORK_W'({frac.mag, {(FRAC_BITS + 1){1'b0}}});
    ctl_s[0].den = frac.den;
    ctl_s[0].rem = '0;
    ctl_s[0].neg = frac.neg;
    ctl_s[0].err = frac.err;
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    dcyf_div_stage #(
      .WORK_W (WORK_W),
      .STEPS  (DIV_STEPS)
    ) u_div (
      .clk_i  (clk_i),
      .load_i (load[FRONT_STAGES + g]),
      .work_i (work_s[g]),
      .ctl_i  (ctl_s[g]),
      .work_o (work_s[g+1]),
      .ctl_o  (ctl_s[g+1])
    );
  end

  // round half up on the extra bit, restore the sign
  always_comb begin
    rounded = (work_s[DIV_STAGES] + WORK_W'(1)) >> 1;
    yf_mag  = rounded[OUT_W-1:0];
    yf_d    = ctl_s[DIV_STAGES].neg ? -yf_mag : yf_mag;
    if (ctl_s[DIV_STAGES].err) begin
      yf_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[NV-1]) begin
      yf_q  <= yf_d;
      err_q <= ctl_s[DIV_STAGES].err;
    end
  end

  assign fraction_o = yf_q;
  assign error_o    = err_q;

  // an error beat always carries a zero fraction
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (fraction_o == '0))
    else $error("error beat with nonzero fraction");

  // input backpressure only when every stage is occupied
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q))
    else $error("input stalled with a bubble in the pipeline");

  // last divider stage leaves a remainder below its divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[NV-2] |-> (ctl_s[DIV_STAGES].rem < ctl_s[DIV_STAGES].den))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// ===== design/dcyf_date_unit.sv =====
`default_nettype none

module dcyf_date_unit import dcyf_pkg::*; #(
  parameter int MIN_YEAR = 1900,
  parameter int MAX_YEAR = 2199
) (
  input  logic               clk_i,
  input  logic               load_s0_i,
  input  logic               load_s1_i,
  input  logic [YEAR_W-1:0]  year_i,
  input  logic [MONTH_W-1:0] month_i,
  input  logic [DAY_W-1:0]   day_i,
  output date_info_t         info_o
);

  logic [YEAR_W+RECIP_W-1:0] prod;
  logic [YEAR_W-1:0]         year_q;
  logic [MONTH_W-1:0]        month_q;
  logic [DAY_W-1:0]          day_q;
  logic [Q100_W-1:0]         q100_q;
  logic [YEAR_W-1:0]         hund;
  logic [YEAR_W-1:0]         r100;
  logic                      r_zero;
  logic                      leap;
  logic [YEAR_W-1:0]         ym1;
  logic [Q100_W-1:0]         qm1;
  logic [DNUM_W-1:0]         leaps_before;
  logic [DAY_W-1:0]          mlen;
  logic [DOY_W-1:0]          doy;
  logic                      year_ok;
  logic                      month_ok;
  logic                      day_ok;
  date_info_t                info_d;
  date_info_t                info_q;

  // century quotient by reciprocal multiply
  assign prod = (YEAR_W + RECIP_W)'(year_i) * (YEAR_W + RECIP_W)'(RECIP_100);

  always_ff @(posedge clk_i) begin
    if (load_s0_i) begin
      year_q  <= year_i;
      month_q <= month_i;
      day_q   <= day_i;
      q100_q  <= prod[RECIP_SHIFT +: Q100_W];
    end
  end

  // leap flag, day of year and linear day number
  always_comb begin
    hund         = YEAR_W'(q100_q) * YEAR_W'(100);
    r100         = year_q - hund;
    r_zero       = (r100 == '0);
    leap         = r_zero ? (q100_q[1:0] == 2'b00) : (year_q[1:0] == 2'b00);
    ym1          = year_q - YEAR_W'(1);
    qm1          = q100_q - Q100_W'(r_zero);
    leaps_before = DNUM_W'(ym1 >> 2) - DNUM_W'(qm1) + DNUM_W'(qm1 >> 2);
    mlen         = month_len(month_q, leap);
    doy          = cum_days(month_q) + DOY_W'(leap && (month_q > 4'd2)) + DOY_W'(day_q);
    year_ok      = (32'(year_q) >= MIN_YEAR) && (32'(year_q) <= MAX_YEAR);
    month_ok     = (month_q >= 4'd1) && (month_q <= 4'd12);
    day_ok       = (day_q != '0) && (day_q <= mlen);

    info_d.year    = year_q;
    info_d.month   = month_q;
    info_d.day     = day_q;
    info_d.doy     = doy;
    info_d.dnum    = DNUM_W'(year_q) * DNUM_W'(365) + leaps_before + DNUM_W'(doy);
    info_d.leap    = leap;
    info_d.feb_end = (month_q == 4'd2) && (day_q == mlen);
    info_d.valid   = year_ok && month_ok && day_ok;
  end

  always_ff @(posedge clk_i) begin
    if (load_s1_i) begin
      info_q <= info_d;
    end
  end

  assign info_o = info_q;

endmodule

`default_nettype wire

// ===== design/dcyf_frac_prep.sv =====
`default_nettype none

module dcyf_frac_prep import dcyf_pkg::*; (
  input  logic              clk_i,
  input  logic              load_s2_i,
  input  logic              load_s3_i,
  input  logic              load_s4_i,
  input  logic [MODE_W-1:0] mode_i,
  input  logic              final_period_i,
  input  date_info_t        start_i,
  input  date_info_t        end_i,
  output frac_t             frac_o
);

  // stage 2 combinational
  logic                      err;
  logic signed [DIFF_W-1:0]  diff;
  logic [DAY_W-1:0]          a_min;
  logic [DAY_W-1:0]          b_min;
  logic [DAY_W-1:0]          a_adj;
  logic [DAY_W:0]            tb;
  logic signed [YDIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0]  num30;
  logic                      swap;
  logic                      same;
  logic [YEAR_W-1:0]         ya;
  logic [YEAR_W-1:0]         yb;
  logic [DOY_W-1:0]          doya;
  logic [DOY_W-1:0]          doyb;
  logic                      leapa;
  logic                      leapb;
  logic [DOY_W-1:0]          la;
  logic [DOY_W-1:0]          lb;
  logic [DEN_W-1:0]          den_aa;

  // stage 2 registers
  logic                      err_s2_q;
  logic [MODE_W-1:0]         mode_s2_q;
  logic signed [DIFF_W-1:0]  diff_s2_q;
  logic signed [DIFF_W-1:0]  num30_s2_q;
  logic signed [YDIFF_W-1:0] t1_q;
  logic [DEN_W-1:0]          den_aa_s2_q;
  logic [DEN_W-1:0]          t2_q;
  logic [DEN_W-1:0]          t3_q;
  logic                      swap_s2_q;
  logic                      same_s2_q;

  // stage 3 registers
  logic                      err_s3_q;
  logic [MODE_W-1:0]         mode_s3_q;
  logic signed [DIFF_W-1:0]  diff_s3_q;
  logic signed [DIFF_W-1:0]  num30_s3_q;
  logic [NUM_W-1:0]          whole_q;
  logic [DEN_W:0]            part_q;
  logic [DEN_W-1:0]          den_aa_s3_q;
  logic                      swap_s3_q;
  logic                      same_s3_q;

  // stage 4
  logic [NUM_W-1:0]          num_aa;
  logic [NUM_W-1:0]          num;
  logic [DEN_W-1:0]          den;
  logic                      neg;
  frac_t                     frac_d;
  frac_t                     frac_q;

  // stage 2: error, actual difference, 30-day count, act/act partial terms
  always_comb begin
    err   = (mode_i > MODE_ACT_ACT) || !start_i.valid || !end_i.valid;
    diff  = DIFF_W'(end_i.dnum) - DIFF_W'(start_i.dnum);
    a_min = (start_i.day > 5'd30) ? 5'd30 : start_i.day;
    b_min = (end_i.day > 5'd30) ? 5'd30 : end_i.day;
    a_adj = a_min;
    tb    = {1'b0, b_min};
    unique case (mode_i)
      MODE_30_360: begin
        if ((end_i.day == 5'd31) && (start_i.day < 5'd30)) begin
          tb = 6'd31;
        end
      end
      MODE_30E_ISDA: begin
        if (start_i.feb_end) begin
          a_adj = 5'd30;
        end
        if (end_i.feb_end && !final_period_i) begin
          tb = 6'd30;
        end
      end
      default: begin
      end
    endcase
    dy    = YDIFF_W'(end_i.year) - YDIFF_W'(start_i.year);
    num30 = DIFF_W'(dy) * DIFF_W'(360)
          + (DIFF_W'({1'b0, end_i.month}) - DIFF_W'({1'b0, start_i.month})) * DIFF_W'(30)
          + DIFF_W'(tb) - DIFF_W'(a_adj);

    swap  = start_i.dnum > end_i.dnum;
    same  = start_i.dnum == end_i.dnum;
    ya    = swap ? end_i.year : start_i.year;
    yb    = swap ? start_i.year : end_i.year;
    doya  = swap ? end_i.doy : start_i.doy;
    doyb  = swap ? start_i.doy : end_i.doy;
    leapa = swap ? end_i.leap : start_i.leap;
    leapb = swap ? start_i.leap : end_i.leap;
    la    = leapa ? DAYS_LEAP : DAYS_COMMON;
    lb    = leapb ? DAYS_LEAP : DAYS_COMMON;
    unique case ({leapa, leapb})
      2'b00:   den_aa = DEN_CC;
      2'b11:   den_aa = DEN_LL;
      default: den_aa = DEN_CL;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_s2_i) begin
      err_s2_q    <= err;
      mode_s2_q   <= mode_i;
      diff_s2_q   <= diff;
      num30_s2_q  <= num30;
      t1_q        <= YDIFF_W'(yb) - YDIFF_W'(ya) - YDIFF_W'(1);
      den_aa_s2_q <= den_aa;
      t2_q        <= DEN_W'(la - doya + DOY_W'(1)) * DEN_W'(lb);
      t3_q        <= DEN_W'(doyb - DOY_W'(1)) * DEN_W'(la);
      swap_s2_q   <= swap;
      same_s2_q   <= same;
    end
  end

  // stage 3: whole years times the combined denominator, plus the partial-year sum
  always_ff @(posedge clk_i) begin
    if (load_s3_i) begin
      err_s3_q    <= err_s2_q;
      mode_s3_q   <= mode_s2_q;
      diff_s3_q   <= diff_s2_q;
      num30_s3_q  <= num30_s2_q;
      whole_q     <= NUM_W'(t1_q) * NUM_W'(den_aa_s2_q);
      part_q      <= (DEN_W + 1)'(t2_q) + (DEN_W + 1)'(t3_q);
      den_aa_s3_q <= den_aa_s2_q;
      swap_s3_q   <= swap_s2_q;
      same_s3_q   <= same_s2_q;
    end
  end

  // stage 4: pick numerator and denominator, split sign and magnitude
  always_comb begin
    num_aa = whole_q + NUM_W'(part_q);
    num    = '0;
    den    = DEN_360;
    unique case (mode_s3_q)
      MODE_ACT360: begin
        num = NUM_W'(diff_s3_q);
      end
      MODE_ACT365F: begin
        num = NUM_W'(diff_s3_q);
        den = DEN_365;
      end
      MODE_30_360, MODE_30E_360, MODE_30E_ISDA: begin
        num = NUM_W'(num30_s3_q);
      end
      MODE_ACT_ACT: begin
        den = den_aa_s3_q;
        if (!same_s3_q) begin
          num = swap_s3_q ? -num_aa : num_aa;
        end
      end
      default: begin
      end
    endcase
    if (err_s3_q) begin
      num = '0;
    end
    neg        = num[NUM_W-1];
    frac_d.mag = MAG_W'(neg ? -num : num);
    frac_d.den = den;
    frac_d.neg = neg;
    frac_d.err = err_s3_q;
  end

  always_ff @(posedge clk_i) begin
    if (load_s4_i) begin
      frac_q <= frac_d;
    end
  end

  assign frac_o = frac_q;

endmodule

`default_nettype wire

// ===== design/dcyf_div_stage.sv =====
`default_nettype none

module dcyf_div_stage import dcyf_pkg::*; #(
  parameter int WORK_W = 66,
  parameter int STEPS  = 6
) (
  input  logic              clk_i,
  input  logic              load_i,
  input  logic [WORK_W-1:0] work_i,
  input  div_ctl_t          ctl_i,
  output logic [WORK_W-1:0] work_o,
  output div_ctl_t          ctl_o
);

  logic [WORK_W-1:0] work;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W:0]    trial;
  logic [WORK_W-1:0] work_q;
  div_ctl_t          ctl_d;
  div_ctl_t          ctl_q;

  // restoring division: dividend bits shift out at the top, quotient bits in at the bottom
  always_comb begin
    work  = work_i;
    rem   = ctl_i.rem;
    trial = '0;
    for (int i = 0; i < STEPS; i++) begin
      trial = {rem, work[WORK_W-1]};
      work  = {work[WORK_W-2:0], 1'b0};
      if (trial >= {1'b0, ctl_i.den}) begin
        trial   = trial - {1'b0, ctl_i.den};
        work[0] = 1'b1;
      end
      rem = trial[DEN_W-1:0];
    end
    ctl_d     = ctl_i;
    ctl_d.rem = rem;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      work_q <= work;
      ctl_q  <= ctl_d;
    end
  end

  assign work_o = work_q;
  assign ctl_o  = ctl_q;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
module testbench import dcyf_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 32;
  localparam int MIN_YEAR  = 1900;
  localparam int MAX_YEAR  = 2199;
  localparam int NUM_ROWS  = 25;
  localparam int NUM_RANDOM = 2000;

  // selectors with no convention behind them
  localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

  localparam logic [OUT_W-1:0] FRAC_ONE     = 42'h001_0000_0000;
  localparam logic [OUT_W-1:0] FRAC_NEG_ONE = 42'h3FF_0000_0000;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;
    logic               final_period;
  } date_pair_t;

  typedef struct packed {
    logic [OUT_W-1:0] frac;
    logic             err;
  } fraction_t;

  typedef struct packed {
    logic      given;
    fraction_t want;
  } known_result_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [YEAR_W-1:0]  sy;
    logic [MONTH_W-1:0] sm;
    logic [DAY_W-1:0]   sd;
    logic [YEAR_W-1:0]  ey;
    logic [MONTH_W-1:0] em;
    logic [DAY_W-1:0]   ed;
    logic               fp;
    logic               given;
    logic [OUT_W-1:0]   frac;
    logic               err;
  } row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [MODE_W-1:0]       mode_i = '0;
  logic [YEAR_W-1:0]       start_year_i = '0;
  logic [MONTH_W-1:0]      start_month_i = '0;
  logic [DAY_W-1:0]        start_day_i = '0;
  logic [YEAR_W-1:0]       end_year_i = '0;
  logic [MONTH_W-1:0]      end_month_i = '0;
  logic [DAY_W-1:0]        end_day_i = '0;
  logic                    final_period_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] fraction_o;
  logic                    error_o;

  known_result_t known_results[$];
  fraction_t     pending_fractions[$];
  int            sent_count = 0;
  int            checked_count = 0;
  int            fail_count = 0;

  day_count_year_fraction_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .start_year_i   (start_year_i),
    .start_month_i  (start_month_i),
    .start_day_i    (start_day_i),
    .end_year_i     (end_year_i),
    .end_month_i    (end_month_i),
    .end_day_i      (end_day_i),
    .final_period_i (final_period_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .fraction_o     (fraction_o),
    .error_o        (error_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // directed rows: error codes, round values and month-end corner cases
  row_t stim_rows [NUM_ROWS] = '{
    '{MODE_RSVD6,    12'd2000, 4'd1,  5'd1,  12'd2001, 4'd1,  5'd1,  1'b0, 1'b1, '0, 1'b1},
    '{MODE_RSVD7,    12'd2000, 4'd1,  5'd1,  12'd2001, 4'd1,  5'd1,  1'b1, 1'b1, '0, 1'b1},
    '{MODE_ACT360,   12'd1899, 4'd12, 5'd31, 12'd2000, 4'd1,  5'd1,  1'b0, 1'b1, '0, 1'b1},
    '{MODE_ACT365F,  12'd2000, 4'd1,  5'd1,  12'd2200, 4'd1,  5'd1,  1'b0, 1'b1, '0, 1'b1},
    '{MODE_30_360,   12'd2000, 4'd0,  5'd1,  12'd2000, 4'd5,  5'd1,  1'b0, 1'b1, '0, 1'b1},
    '{MODE_30E_360,  12'd2000, 4'd13, 5'd1,  12'd2000, 4'd5,  5'd1,  1'b0, 1'b1, '0, 1'b1},
    '{MODE_30E_ISDA, 12'd2000, 4'd3,  5'd0,  12'd2000, 4'd5,  5'd1,  1'b0, 1'b1, '0, 1'b1},
    '{MODE_ACT_ACT,  12'd1900, 4'd2,  5'd29, 12'd1901, 4'd1,  5'd1,  1'b0, 1'b1, '0, 1'b1},
    '{MODE_ACT360,   12'd2001, 4'd4,  5'd31, 12'd2001, 4'd5,  5'd1,  1'b0, 1'b1, '0, 1'b1},
    '{MODE_ACT365F,  12'd2001, 4'd1,  5'd1,  12'd4095, 4'd15, 5'd31, 1'b1, 1'b1, '0, 1'b1},
    '{MODE_30_360,   12'd0,    4'd0,  5'd0,  12'd2001, 4'd1,  5'd1,  1'b0, 1'b1, '0, 1'b1},
    '{MODE_ACT360,   12'd2001, 4'd1,  5'd1,  12'd2001, 4'd12, 5'd27, 1'b0, 1'b1, FRAC_ONE, 1'b0},
    '{MODE_ACT365F,  12'd2001, 4'd1,  5'd1,  12'd2002, 4'd1,  5'd1,  1'b0, 1'b1, FRAC_ONE, 1'b0},
    '{MODE_30_360,   12'd2000, 4'd1,  5'd1,  12'd2001, 4'd1,  5'd1,  1'b0, 1'b1, FRAC_ONE, 1'b0},
    '{MODE_30_360,   12'd2001, 4'd1,  5'd1,  12'd2000, 4'd1,  5'd1,  1'b0, 1'b1, FRAC_NEG_ONE,
      1'b0},
    '{MODE_ACT_ACT,  12'd2000, 4'd2,  5'd29, 12'd2000, 4'd2,  5'd29, 1'b0, 1'b1, '0, 1'b0},
    '{MODE_30_360,   12'd2003, 4'd1,  5'd31, 12'd2003, 4'd3,  5'd31, 1'b0, 1'b0, '0, 1'b0},
    '{MODE_30_360,   12'd2003, 4'd1,  5'd15, 12'd2003, 4'd3,  5'd31, 1'b0, 1'b0, '0, 1'b0},
    '{MODE_30E_360,  12'd2003, 4'd1,  5'd31, 12'd2003, 4'd3,  5'd31, 1'b0, 1'b0, '0, 1'b0},
    '{MODE_30E_ISDA, 12'd2004, 4'd2,  5'd29, 12'd2005, 4'd2,  5'd28, 1'b0, 1'b0, '0, 1'b0},
    '{MODE_30E_ISDA, 12'd2004, 4'd2,  5'd29, 12'd2005, 4'd2,  5'd28, 1'b1, 1'b0, '0, 1'b0},
    '{MODE_30E_ISDA, 12'd2003, 4'd8,  5'd31, 12'd2004, 4'd2,  5'd29, 1'b0, 1'b0, '0, 1'b0},
    '{MODE_ACT_ACT,  12'd2005, 4'd6,  5'd15, 12'd2003, 4'd11, 5'd2,  1'b0, 1'b0, '0, 1'b0},
    '{MODE_ACT_ACT,  12'd1900, 4'd1,  5'd1,  12'd2199, 4'd12, 5'd31, 1'b0, 1'b0, '0, 1'b0},
    '{MODE_ACT360,   12'd2199, 4'd12, 5'd31, 12'd1900, 4'd1,  5'd1,  1'b0, 1'b0, '0, 1'b0}
  };

  // calendar helpers
  function automatic bit is_leap(int y);
    return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(int y, int m);
    case (m)
      2:           return is_leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic bit date_valid(int y, int m, int d);
    if (y < MIN_YEAR || y > MAX_YEAR || m < 1 || m > 12 || d < 1)
      return 1'b0;
    return d <= days_in_month(y, m);
  endfunction

  function automatic int day_in_year(int y, int m, int d);
    int doy;
    doy = d;
    for (int k = 1; k < m; k++)
      doy += days_in_month(y, k);
    return doy;
  endfunction

  // running day count, only differences are used
  function automatic longint day_serial(int y, int m, int d);
    longint p;
    p = longint'(y - 1);
    return 365 * p + p / 4 - p / 100 + p / 400 + longint'(day_in_year(y, m, d));
  endfunction

  // num / den scaled to FRAC_BITS, nearest with ties away from zero
  function automatic logic [OUT_W-1:0] round_fixed(longint num, longint den);
    longint unsigned mag, dv, quo, rem;
    mag = (num < 0) ? -num : num;
    dv = den;
    quo = (mag << FRAC_BITS) / dv;
    rem = (mag << FRAC_BITS) % dv;
    if (2 * rem >= dv)
      quo++;
    if (num < 0)
      quo = -quo;
    return quo[OUT_W-1:0];
  endfunction

  // 30E/360 ISDA day adjustment
  function automatic int isda_day(int y, int m, int d, bit keep_feb_end);
    if (m == 2 && d == days_in_month(y, m) && !keep_feb_end)
      return 30;
    return (d > 30) ? 30 : d;
  endfunction

  // expected result of one date pair
  function automatic fraction_t expected_result(date_pair_t p);
    fraction_t r;
    int y1, m1, d1, y2, m2, d2, a, b, mb, la, lb;
    int ya, ma, da, yb, mbb, db;
    longint num, den, s1, s2;
    bit swap;
    y1 = int'(p.start_year);
    m1 = int'(p.start_month);
    d1 = int'(p.start_day);
    y2 = int'(p.end_year);
    m2 = int'(p.end_month);
    d2 = int'(p.end_day);
    r.frac = '0;
    r.err = 1'b1;
    if (p.mode > MODE_ACT_ACT || !date_valid(y1, m1, d1) || !date_valid(y2, m2, d2))
      return r;
    num = 0;
    den = 360;
    case (p.mode)
      MODE_ACT360, MODE_ACT365F: begin
        num = day_serial(y2, m2, d2) - day_serial(y1, m1, d1);
        if (p.mode == MODE_ACT365F)
          den = 365;
      end
      MODE_30_360, MODE_30E_360: begin
        a = d1;
        b = d2;
        mb = m2;
        // US rule: end 31 rolls to the next month unless start is 30 or 31
        if (p.mode == MODE_30_360 && b == 31 && a < 30) begin
          b = 1;
          mb++;
        end
        num = 360 * (y2 - y1) + 30 * (mb - m1 - 1) + ((a < 30) ? 30 - a : 0)
            + ((b < 30) ? b : 30);
      end
      MODE_30E_ISDA: begin
        a = isda_day(y1, m1, d1, 1'b0);
        b = isda_day(y2, m2, d2, p.final_period);
        num = 360 * (y2 - y1) + 30 * (m2 - m1 - 1) + (30 - a) + b;
      end
      default: begin
        s1 = day_serial(y1, m1, d1);
        s2 = day_serial(y2, m2, d2);
        if (s1 == s2) begin
          num = 0;
          den = 1;
        end else begin
          swap = s1 > s2;
          ya = swap ? y2 : y1;
          ma = swap ? m2 : m1;
          da = swap ? d2 : d1;
          yb = swap ? y1 : y2;
          mbb = swap ? m1 : m2;
          db = swap ? d1 : d2;
          la = is_leap(ya) ? 366 : 365;
          lb = is_leap(yb) ? 366 : 365;
          den = la * lb;
          num = (yb - ya - 1) * den + longint'(la - day_in_year(ya, ma, da) + 1) * lb
              + longint'(day_in_year(yb, mbb, db) - 1) * la;
          if (swap)
            num = -num;
        end
      end
    endcase
    r.frac = round_fixed(num, den);
    r.err = 1'b0;
    return r;
  endfunction

  // random calendar date, weighted toward month ends, February and range ends
  function automatic void pick_date(input int hint, output int y, output int m, output int d);
    int r, len;
    r = $urandom_range(0, 9);
    if (hint > 0)
      y = hint + $urandom_range(0, 2) - 1;
    else if (r == 0)
      y = $urandom_range(MIN_YEAR, MIN_YEAR + 4);
    else if (r == 1)
      y = $urandom_range(MAX_YEAR - 4, MAX_YEAR);
    else if (r == 2)
      y = ($urandom_range(0, 1) == 1) ? 2000 : 2100;
    else
      y = $urandom_range(MIN_YEAR, MAX_YEAR);
    if (y < MIN_YEAR)
      y = MIN_YEAR;
    if (y > MAX_YEAR)
      y = MAX_YEAR;
    m = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 12);
    len = days_in_month(y, m);
    case ($urandom_range(0, 3))
      0:       d = len;
      1:       d = (len >= 30) ? $urandom_range(29, len) : $urandom_range(len - 1, len);
      default: d = $urandom_range(1, len);
    endcase
  endfunction

  // random beat: mostly valid pairs, some raw noise, some unused selectors and some broken dates
  function automatic date_pair_t random_pair();
    date_pair_t p;
    longint unsigned raw;
    int kind, y, m, d;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      raw = {$urandom, $urandom};
      p = raw[$bits(date_pair_t)-1:0];
      return p;
    end
    p.mode = (kind < 9) ? MODE_W'($urandom_range(MODE_RSVD6, MODE_RSVD7))
                        : MODE_W'($urandom_range(MODE_ACT360, MODE_ACT_ACT));
    p.final_period = 1'($urandom_range(0, 1));
    pick_date(0, y, m, d);
    p.start_year = YEAR_W'(y);
    p.start_month = MONTH_W'(m);
    p.start_day = DAY_W'(d);
    pick_date(($urandom_range(0, 1) == 1) ? y : 0, y, m, d);
    p.end_year = YEAR_W'(y);
    p.end_month = MONTH_W'(m);
    p.end_day = DAY_W'(d);
    // break one date
    if (kind < 14) begin
      case ($urandom_range(0, 4))
        0: p.start_day = '0;
        1: p.end_day = (days_in_month(y, m) < 31) ? 5'd31 : 5'd0;
        2: p.start_month = ($urandom_range(0, 1) == 1) ? MONTH_W'($urandom_range(13, 15))
                                                       : 4'd0;
        3: p.end_year = YEAR_W'($urandom_range(0, MIN_YEAR - 1));
        default: p.start_year = YEAR_W'($urandom_range(MAX_YEAR + 1, 4095));
      endcase
    end
    return p;
  endfunction

  // idle length: mostly none, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one beat and hold it until accepted
  task automatic send_pair(input date_pair_t p, input known_result_t known, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    known_results.insert(known_results.size(), known);
    in_valid_i     <= 1'b1;
    mode_i         <= p.mode;
    start_year_i   <= p.start_year;
    start_month_i  <= p.start_month;
    start_day_i    <= p.start_day;
    end_year_i     <= p.end_year;
    end_month_i    <= p.end_month;
    end_day_i      <= p.end_day;
    final_period_i <= p.final_period;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
  endtask

  // reset and stimulus
  initial begin
    date_pair_t    p;
    known_result_t known;
    row_t          r;
    int            gap;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    for (int i = 0; i < NUM_ROWS; i++) begin
      r = stim_rows[i];
      p = {r.mode, r.sy, r.sm, r.sd, r.ey, r.em, r.ed, r.fp};
      known.given = r.given;
      known.want.frac = r.frac;
      known.want.err = r.err;
      send_pair(p, known, pick_gap());
    end

    // random beats
    known = '0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      // let the pipeline drain completely once
      if (i == 1000) begin
        in_valid_i <= 1'b0;
        wait (checked_count == sent_count);
        @(posedge clk_i);
      end
      // back-to-back window so that a long output stall fills the pipeline
      gap = (i >= 300 && i < 800) ? 0 : pick_gap();
      send_pair(random_pair(), known, gap);
    end
    in_valid_i <= 1'b0;

    wait (checked_count == sent_count);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  // output ready with random stalls, one long hold and one stall-free stretch
  initial begin
    bit long_hold_done;
    int gap;
    long_hold_done = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (checked_count >= 350 && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (150) @(posedge clk_i);
      end else begin
        gap = (checked_count >= 1200 && checked_count < 1400) ? 0 : pick_gap();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // record accepted beats and check each result against the oldest expectation
  always @(posedge clk_i) begin : monitor
    date_pair_t    seen;
    known_result_t known;
    fraction_t     want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        seen = {mode_i, start_year_i, start_month_i, start_day_i, end_year_i, end_month_i,
                end_day_i, final_period_i};
        known = known_results.pop_front();
        pending_fractions.insert(pending_fractions.size(),
                                 known.given ? known.want : expected_result(seen));
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_fractions.size() == 0) begin
          $display("%0t: result with nothing expected: fraction %h error %b",
                   $time, fraction_o, error_o);
          fail_count++;
        end else begin
          want = pending_fractions.pop_front();
          if (fraction_o !== want.frac) begin
            $display("%0t: fraction expected %h actual %h", $time, want.frac,
                     fraction_o);
            fail_count++;
          end
          if (error_o !== want.err) begin
            $display("%0t: error expected %b actual %b", $time, want.err, error_o);
            fail_count++;
          end
          checked_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
